### hdl/infix_to_postfix_converter_unit_defines.svh
// Assertion macros shared by the converter RTL.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define ITP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ITP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ITP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/itp_pkg.sv
// Package for the infix to postfix converter: item types, stack entry
// format, token and result codes and the helpers that build result items.
`default_nettype none

package itp_pkg;

  localparam logic [2:0] CMD_NUMBER = 3'd0;
  localparam logic [2:0] CMD_FUNC   = 3'd1;
  localparam logic [2:0] CMD_OPER   = 3'd2;
  localparam logic [2:0] CMD_LPAREN = 3'd3;
  localparam logic [2:0] CMD_RPAREN = 3'd4;
  localparam logic [2:0] CMD_COMMA  = 3'd5;
  localparam logic [2:0] CMD_END    = 3'd6;

  localparam logic [1:0] TAG_OPER = 2'd0;
  localparam logic [1:0] TAG_FUNC = 2'd1;
  localparam logic [1:0] TAG_LPAR = 2'd2;

  localparam logic [1:0] KIND_NUMBER = 2'd0;
  localparam logic [1:0] KIND_FUNC   = 2'd1;
  localparam logic [1:0] KIND_OPER   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_PAREN    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [1:0]  op_code;
    logic [7:0]  func_id;
    logic [31:0] number_value;
  } token_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [1:0]  out_op;
    logic [7:0]  out_func;
    logic [31:0] out_value;
    logic [1:0]  error;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] tag;
    logic [1:0] op;
    logic [7:0] fid;
  } entry_t;

  typedef struct packed {
    logic    valid;
    result_t item;
  } emit_t;

  function automatic result_t pop_result(input entry_t e);
    result_t r;
    r = '0;
    if (e.tag == TAG_FUNC) begin
      r.out_kind = KIND_FUNC;
      r.out_func = e.fid;
    end else begin
      r.out_kind = KIND_OPER;
      r.out_op   = e.op;
    end
    return r;
  endfunction

  function automatic result_t error_result(input logic [1:0] code);
    result_t r;
    r       = '0;
    r.error = code;
    r.last  = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/itp_stack_ram.sv
// Operator stack storage: one write port and one registered read port.
// Depends on itp_pkg for the entry type.
`default_nettype none

module itp_stack_ram
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/itp_ctrl.sv
// Shunting-yard sequencer: reads the stack top, pops, pushes and builds
// result items. Depends on itp_pkg and the assertion macro header.
`default_nettype none
`include "infix_to_postfix_converter_unit_defines.svh"

module itp_ctrl
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          token_valid,
  input  wire token_t        token,
  output logic               busy,
  input  wire logic          out_free,
  output emit_t              emit,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire entry_t        mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EVAL = 4'b0010,
    ST_FUNC = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [2:0]  cmd;
  logic [1:0]  opc;
  logic [7:0]  fid;
  logic [31:0] val;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] lp_cnt, lp_cnt_next;
  logic        held_v, held_v_next;
  result_t     held, held_next;

  logic [CW-1:0] cnt_m1, cnt_m2;
  logic        cnt_full;
  logic        do_pop, do_fin, go;
  logic        we_raw, re_raw;
  entry_t      top;

  assign top      = mem_rdata;
  assign cnt_m1   = cnt - CW'(1);
  assign cnt_m2   = cnt - CW'(2);
  assign cnt_full = (cnt == CW'(STACK_DEPTH));
  assign busy     = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    lp_cnt_next  = lp_cnt;
    held_v_next  = held_v;
    held_next    = held;
    emit         = '0;
    we_raw       = 1'b0;
    mem_waddr    = cnt[AW-1:0];
    mem_wdata    = '0;
    re_raw       = 1'b0;
    mem_raddr    = cnt_m1[AW-1:0];
    do_pop       = 1'b0;
    do_fin       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (token_valid) begin
          re_raw     = (cnt != '0);
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (cmd)
          CMD_NUMBER: begin
            emit.valid          = 1'b1;
            emit.item.out_kind  = KIND_NUMBER;
            emit.item.out_value = val;
            emit.item.last      = 1'b1;
            state_next          = ST_IDLE;
          end
          CMD_FUNC, CMD_LPAREN: begin
            if (cnt_full) begin
              emit.valid  = 1'b1;
              emit.item   = error_result(ERR_OVERFLOW);
              cnt_next    = '0;
              lp_cnt_next = '0;
            end else begin
              we_raw = 1'b1;
              if (cmd == CMD_FUNC) begin
                mem_wdata.tag = TAG_FUNC;
                mem_wdata.fid = fid;
              end else begin
                mem_wdata.tag = TAG_LPAR;
                lp_cnt_next   = lp_cnt + CW'(1);
              end
              cnt_next = cnt + CW'(1);
            end
            state_next = ST_IDLE;
          end
          CMD_OPER: begin
            if (cnt != '0 && top.tag == TAG_OPER && (top.op[1] || !opc[1])) begin
              do_pop = 1'b1;
            end else if (cnt_full) begin
              emit.valid  = 1'b1;
              emit.item   = error_result(ERR_OVERFLOW);
              cnt_next    = '0;
              lp_cnt_next = '0;
              state_next  = ST_IDLE;
            end else begin
              we_raw        = 1'b1;
              mem_wdata.tag = TAG_OPER;
              mem_wdata.op  = opc;
              cnt_next      = cnt + CW'(1);
              do_fin        = 1'b1;
            end
          end
          CMD_RPAREN, CMD_COMMA: begin
            if (lp_cnt == '0) begin
              emit.valid  = 1'b1;
              emit.item   = error_result(ERR_PAREN);
              cnt_next    = '0;
              lp_cnt_next = '0;
              state_next  = ST_IDLE;
            end else if (top.tag != TAG_LPAR) begin
              do_pop = 1'b1;
            end else if (cmd == CMD_COMMA) begin
              do_fin = 1'b1;
            end else begin
              cnt_next    = cnt_m1;
              lp_cnt_next = lp_cnt - CW'(1);
              re_raw      = (cnt_m1 != '0);
              mem_raddr   = cnt_m2[AW-1:0];
              state_next  = ST_FUNC;
            end
          end
          CMD_END: begin
            if (lp_cnt != '0) begin
              emit.valid  = 1'b1;
              emit.item   = error_result(ERR_PAREN);
              cnt_next    = '0;
              lp_cnt_next = '0;
              state_next  = ST_IDLE;
            end else if (cnt != '0) begin
              do_pop = 1'b1;
            end else begin
              do_fin = 1'b1;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_FUNC: begin
        if (cnt != '0 && top.tag == TAG_FUNC) begin
          do_pop = 1'b1;
        end else begin
          do_fin = 1'b1;
        end
      end
      ST_FIN: begin
        if (held_v) begin
          emit.valid     = 1'b1;
          emit.item      = held;
          emit.item.last = 1'b1;
        end
        held_v_next = 1'b0;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (do_pop) begin
      if (held_v) begin
        emit.valid     = 1'b1;
        emit.item      = held;
        emit.item.last = 1'b0;
      end
      held_next   = pop_result(top);
      held_v_next = 1'b1;
      cnt_next    = cnt_m1;
      re_raw      = (cnt_m1 != '0);
      mem_raddr   = cnt_m2[AW-1:0];
      if (state == ST_FUNC) begin
        state_next = ST_FIN;
      end
    end

    if (do_fin) begin
      state_next = held_v ? ST_FIN : ST_IDLE;
    end
  end

  assign go     = !emit.valid || out_free;
  assign mem_we = we_raw && go;
  assign mem_re = re_raw && go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      lp_cnt <= '0;
      held_v <= 1'b0;
    end else if (go) begin
      state  <= state_next;
      cnt    <= cnt_next;
      lp_cnt <= lp_cnt_next;
      held_v <= held_v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && token_valid) begin
      cmd <= token.command;
      opc <= token.op_code;
      fid <= token.func_id;
      val <= token.number_value;
    end
    if (go) begin
      held <= held_next;
    end
  end

  `ITP_ASSERT_ALWAYS(a_lp_within_cnt, lp_cnt <= cnt, "left parenthesis count exceeds stack count")
  `ITP_ASSERT_ALWAYS(a_cnt_within_depth, cnt <= CW'(STACK_DEPTH), "stack count exceeds depth")
  `ITP_ASSERT_IMP(a_idle_no_held, state == ST_IDLE, !held_v, "held pop left over in idle")
  `ITP_ASSERT_IMP(a_error_alone, emit.valid && emit.item.error != ERR_NONE, !held_v, "error with pending pop")
  `ITP_ASSERT_NXT(a_push_counts, mem_we, cnt == CW'($past(cnt) + CW'(1)), "push did not grow stack")

endmodule

`default_nettype wire

### hdl/infix_to_postfix_converter_unit.sv
// Number path: a token is latched in the idle state and emitted from the evaluate state.
// Flow: one token at a time, with a pop step per popped entry, a finish step
// when anything was popped, and a function step for each matched right parenthesis;
// the single read port of the stack memory sets the pop rate, and output stalls hold any step that emits.
// Reset: synchronous; empties the stack and output register, memory is not cleared.
// Depends on itp_pkg, itp_ctrl and itp_stack_ram.
`default_nettype none

module infix_to_postfix_converter_unit
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   token_valid,
  output logic        token_stall,
  input  wire token_t token,
  output logic        result_valid,
  input  wire logic   result_stall,
  output result_t     result
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic          busy;
  logic          out_free;
  emit_t         emit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  assign token_stall = busy || rst;
  assign out_free    = !result_valid || !result_stall;

  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .token_valid(token_valid),
    .token      (token),
    .busy       (busy),
    .out_free   (out_free),
    .emit       (emit),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  itp_stack_ram #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit.valid && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid && out_free) begin
      result <= emit.item;
    end
  end

endmodule

`default_nettype wire
